FILE: rtl/core/ialu_pkg.sv
// Shared types for the integer ALU: operation codes, status codes and the
// per-item control word passed from front end through the queue to the back end.
// No dependencies.
`default_nettype none
package ialu_pkg;

	typedef enum logic [3:0] {
		K_ADD  = 4'd0,
		K_SUB  = 4'd1,
		K_MUL  = 4'd2,
		K_DIV  = 4'd3,
		K_REM  = 4'd4,
		K_XOR  = 4'd5,
		K_AND  = 4'd6,
		K_OR   = 4'd7,
		K_SHL  = 4'd8,
		K_SHR  = 4'd9,
		K_NOT  = 4'd10,
		K_NONE = 4'd15
	} kind_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_REMZERO = 2'd2;

	typedef struct packed {
		kind_t kind;
		logic  bz;    // operand_b is zero
	} ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/integer_alu_with_divide.sv
// Top level of the unsigned integer ALU with pipelined divide.
// Depends on ialu_pkg, ialu_front, ialu_fifo and ialu_back.
//
// Usage:
//  Input channel: in_valid / in_stall with operation, operand_a, operand_b.
//  An item is taken on a rising edge with in_valid high and in_stall low.
//  Output channel: out_valid / out_stall with result and status, one
//  result item per input item, in input order.
//  Throughput: one item per cycle, sustained while out_stall is low, for every operation mix.
//  Each accepted item passes the front register, the queue, the divider
//  stages and the output register. The restoring divider retires one quotient
//  bit per stage, so its DATA_WIDTH stages set the depth; all operations
//  travel the same pipeline to keep order. Shifts reuse the divider to
//  reduce the amount modulo DATA_WIDTH.
//  Multiply is split into half-width partial products, summed a stage later.
//  Reset: arst_n clears all valid flags; no item is in flight after reset.
//  Receiver stall: the whole back pipeline holds while out_stall is high
//  and a result is waiting; the two-entry queue and front register absorb
//  items, then in_stall rises. Result and status hold while stalled.
`default_nettype none
module integer_alu_with_divide #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [3:0]            operation,
	input  wire logic [DATA_WIDTH-1:0] operand_a,
	input  wire logic [DATA_WIDTH-1:0] operand_b,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [DATA_WIDTH-1:0]      result,
	output logic [1:0]                 status
);
	import ialu_pkg::*;

	localparam int DW = DATA_WIDTH;

	logic          f_valid, q_full, q_empty, q_pop;
	ctl_t          f_ctl, h_ctl;
	logic [DW-1:0] f_a, f_b, f_dvd, f_dvs;
	logic [4*DW-1:0] h_data;

	ialu_front #(.DW(DW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.f_valid   (f_valid),
		.f_full    (q_full),
		.f_ctl     (f_ctl),
		.f_a       (f_a),
		.f_b       (f_b),
		.f_dvd     (f_dvd),
		.f_dvs     (f_dvs)
	);

	// queue decouples decode from the execution pipeline
	ialu_fifo #(.DW(DW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.w_ctl  (f_ctl),
		.w_data ({f_a, f_b, f_dvd, f_dvs}),
		.full   (q_full),
		.empty  (q_empty),
		.pop    (q_pop),
		.r_ctl  (h_ctl),
		.r_data (h_data)
	);

	ialu_back #(.DW(DW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.h_ctl     (h_ctl),
		.h_a       (h_data[4*DW-1:3*DW]),
		.h_b       (h_data[3*DW-1:2*DW]),
		.h_dvd     (h_data[2*DW-1:DW]),
		.h_dvs     (h_data[DW-1:0]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result),
		.status    (status)
	);
endmodule
`default_nettype wire

FILE: rtl/core/ialu_front.sv
// Front end: input register and operation decode.
// Depends on ialu_pkg.
`default_nettype none
module ialu_front #(
	parameter int DW = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [3:0]      operation,
	input  wire logic [DW-1:0]   operand_a,
	input  wire logic [DW-1:0]   operand_b,
	output logic                 f_valid,
	input  wire logic            f_full,
	output ialu_pkg::ctl_t       f_ctl,
	output logic [DW-1:0]        f_a,
	output logic [DW-1:0]        f_b,
	output logic [DW-1:0]        f_dvd,
	output logic [DW-1:0]        f_dvs
);
	import ialu_pkg::*;

	logic   v_q;
	ctl_t   ctl_q;
	logic [DW-1:0] a_q, b_q, dvd_q, dvs_q;
	kind_t  kind_d;
	logic   take;

	assign in_stall = v_q && f_full;
	assign take     = in_valid && !in_stall;

	always_comb begin
		unique case (operation)
			K_ADD:   kind_d = K_ADD;
			K_SUB:   kind_d = K_SUB;
			K_MUL:   kind_d = K_MUL;
			K_DIV:   kind_d = K_DIV;
			K_REM:   kind_d = K_REM;
			K_XOR:   kind_d = K_XOR;
			K_AND:   kind_d = K_AND;
			K_OR:    kind_d = K_OR;
			K_SHL:   kind_d = K_SHL;
			K_SHR:   kind_d = K_SHR;
			K_NOT:   kind_d = K_NOT;
			default: kind_d = K_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!in_stall) begin
			v_q <= in_valid;
		end
	end

	// shifts borrow the divider: operand_b mod DW gives the amount
	always_ff @(posedge clk) begin
		if (take) begin
			ctl_q.kind <= kind_d;
			ctl_q.bz   <= (operand_b == '0);
			a_q        <= operand_a;
			b_q        <= operand_b;
			if (kind_d == K_SHL || kind_d == K_SHR) begin
				dvd_q <= operand_b;
				dvs_q <= DW'(DW);
			end else begin
				dvd_q <= operand_a;
				dvs_q <= operand_b;
			end
		end
	end

	assign f_valid = v_q;
	assign f_ctl   = ctl_q;
	assign f_a     = a_q;
	assign f_b     = b_q;
	assign f_dvd   = dvd_q;
	assign f_dvs   = dvs_q;
endmodule
`default_nettype wire

FILE: rtl/core/ialu_fifo.sv
// Two-entry queue between front end and back end.
// Depends on ialu_pkg.
`default_nettype none
module ialu_fifo #(
	parameter int DW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ialu_pkg::ctl_t w_ctl,
	input  wire logic [4*DW-1:0] w_data,
	output logic               full,
	output logic               empty,
	input  wire logic          pop,
	output ialu_pkg::ctl_t     r_ctl,
	output logic [4*DW-1:0]    r_data
);
	import ialu_pkg::*;

	ctl_t            ctl_mem [2];
	logic [4*DW-1:0] dat_mem [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ctl_mem[wp_q] <= w_ctl;
			dat_mem[wp_q] <= w_data;
		end
	end

	assign r_ctl  = ctl_mem[rp_q];
	assign r_data = dat_mem[rp_q];
endmodule
`default_nettype wire

FILE: rtl/core/ialu_back.sv
// Back end: execution pipeline with a one-bit-per-stage restoring divider,
// a split multiplier and the result select. Depends on ialu_pkg.
`default_nettype none
module ialu_back #(
	parameter int DW = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	output logic                q_pop,
	input  wire ialu_pkg::ctl_t h_ctl,
	input  wire logic [DW-1:0]  h_a,
	input  wire logic [DW-1:0]  h_b,
	input  wire logic [DW-1:0]  h_dvd,
	input  wire logic [DW-1:0]  h_dvs,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [DW-1:0]       result,
	output logic [1:0]          status
);
	import ialu_pkg::*;

	localparam int L  = DW / 2;
	localparam int H  = DW - L;
	localparam int SW = $clog2(DW);

	logic en;
	logic [DW:1]   v_s;
	kind_t         kind_s [1:DW];
	logic          bz_s   [1:DW];
	logic [DW-1:0] a_s    [1:DW];
	logic [DW-1:0] res_s  [1:DW];
	logic [DW-1:0] r_s    [1:DW];
	logic [DW-1:0] nq_s   [1:DW];
	logic [DW-1:0] d_s    [1:DW-1];

	// multiplier partial products
	logic [2*L-1:0] a_lo, b_lo;
	logic [H-1:0]   a_hi, b_hi;
	logic [2*L-1:0] pll_s1;
	logic [H-1:0]   pc1_s1, pc2_s1;
	logic [H-1:0]   pcs;
	logic [DW-1:0]  prod;
	logic [DW-1:0]  alu;

	logic          out_v_q;
	logic [DW-1:0] res_q;
	logic [1:0]    st_q;

	assign en    = !out_v_q || !out_stall;
	assign q_pop = en && !q_empty;

	assign a_lo = {{L{1'b0}}, h_a[L-1:0]};
	assign b_lo = {{L{1'b0}}, h_b[L-1:0]};
	assign a_hi = h_a[DW-1:L];
	assign b_hi = h_b[DW-1:L];

	always_comb begin
		case (h_ctl.kind)
			K_ADD:   alu = h_a + h_b;
			K_SUB:   alu = h_a - h_b;
			K_XOR:   alu = h_a ^ h_b;
			K_AND:   alu = h_a & h_b;
			K_OR:    alu = h_a | h_b;
			K_NOT:   alu = ~h_a;
			default: alu = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= a_lo * b_lo;
			pc1_s1 <= H'(a_lo[L-1:0] * b_hi);
			pc2_s1 <= H'(a_hi * b_lo[L-1:0]);
		end
	end

	assign pcs  = pc1_s1 + pc2_s1;
	assign prod = DW'(pll_s1) + {pcs, {L{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DW-1:1], q_pop};
		end
	end

	for (genvar k = 1; k <= DW; k++) begin : g_stage
		logic [DW-1:0] p_r, p_nq, p_d;
		logic [DW:0]   t;
		logic          ge;

		if (k == 1) begin : g_first
			assign p_r  = '0;
			assign p_nq = h_dvd;
			assign p_d  = h_dvs;
			always_ff @(posedge clk) begin
				if (en) begin
					kind_s[1] <= h_ctl.kind;
					bz_s[1]   <= h_ctl.bz;
					a_s[1]    <= h_a;
					res_s[1]  <= alu;
				end
			end
		end else begin : g_next
			assign p_r  = r_s[k-1];
			assign p_nq = nq_s[k-1];
			assign p_d  = d_s[k-1];
			always_ff @(posedge clk) begin
				if (en) begin
					kind_s[k] <= kind_s[k-1];
					bz_s[k]   <= bz_s[k-1];
					a_s[k]    <= a_s[k-1];
					if (k == 2 && kind_s[k-1] == K_MUL) begin
						res_s[k] <= prod;
					end else begin
						res_s[k] <= res_s[k-1];
					end
				end
			end
		end

		// one restoring divide step
		assign t  = {p_r, p_nq[DW-1]};
		assign ge = (t >= {1'b0, p_d});

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]  <= ge ? DW'(t - {1'b0, p_d}) : t[DW-1:0];
				nq_s[k] <= {p_nq[DW-2:0], ge};
			end
		end

		if (k < DW) begin : g_dvs
			always_ff @(posedge clk) begin
				if (en) d_s[k] <= p_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= ST_OK;
			case (kind_s[DW])
				K_DIV: begin
					res_q <= bz_s[DW] ? '0 : nq_s[DW];
					if (bz_s[DW]) st_q <= ST_DIVZERO;
				end
				K_REM: begin
					res_q <= bz_s[DW] ? '0 : r_s[DW];
					if (bz_s[DW]) st_q <= ST_REMZERO;
				end
				K_SHL:   res_q <= a_s[DW] << r_s[DW][SW-1:0];
				K_SHR:   res_q <= a_s[DW] >> r_s[DW][SW-1:0];
				default: res_q <= res_s[DW];
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign result    = res_q;
	assign status    = st_q;
endmodule
`default_nettype wire

FILE: rtl/core/ialu_checker.sv
// Port-level checks for the integer ALU, bound to the top level.
// Depends on ialu_pkg and integer_alu_with_divide.
`default_nettype none
module ialu_port_checks #(
	parameter int DATA_WIDTH = 64
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic [3:0]            operation,
	input wire logic [DATA_WIDTH-1:0] operand_a,
	input wire logic [DATA_WIDTH-1:0] operand_b,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [DATA_WIDTH-1:0] result,
	input wire logic [1:0]            status
);
	import ialu_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(status))
		else $error("stalled result changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_DIVZERO || status == ST_REMZERO))
		else $error("bad status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result == '0)
		else $error("error item with nonzero result");
endmodule

bind integer_alu_with_divide ialu_port_checks #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);
`default_nettype wire

FILE: bench/ialu_checker.sv
// Result checker for integer_alu_with_divide: watches both channels, predicts each result.
// Depends on ialu_pkg.
`default_nettype none
module ialu_checker #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [3:0]            operation,
	input  wire logic [DATA_WIDTH-1:0] operand_a,
	input  wire logic [DATA_WIDTH-1:0] operand_b,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [DATA_WIDTH-1:0] result,
	input  wire logic [1:0]            status,
	output int                         errors,
	output int                         pending
);
	import ialu_pkg::*;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic [1:0]            st;
	} alu_out_t;

	alu_out_t expected_q[$];

	function automatic alu_out_t compute_alu(logic [3:0] op, logic [DATA_WIDTH-1:0] a,
			logic [DATA_WIDTH-1:0] b);
		alu_out_t r;
		int unsigned sh;
		r.value = '0;
		r.st = ST_OK;
		sh = int'(b % DATA_WIDTH);
		case (kind_t'(op))
			K_ADD: r.value = a + b;
			K_SUB: r.value = a - b;
			K_MUL: r.value = a * b;
			K_DIV: begin
				if (b != 0) r.value = a / b;
				else r.st = ST_DIVZERO;
			end
			K_REM: begin
				if (b != 0) r.value = a % b;
				else r.st = ST_REMZERO;
			end
			K_XOR: r.value = a ^ b;
			K_AND: r.value = a & b;
			K_OR:  r.value = a | b;
			K_SHL: r.value = a << sh;
			K_SHR: r.value = a >> sh;
			K_NOT: r.value = ~a;
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		alu_out_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_q.push_back(compute_alu(operation, operand_a, operand_b));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("result item with nothing expected");
				end else begin
					e = expected_q.pop_front();
					if (result !== e.value)
						report($sformatf("result %h, expected %h", result, e.value));
					if (status !== e.st)
						report($sformatf("status %0d, expected %0d", status, e.st));
				end
			end
		end
		pending <= expected_q.size();
	end
endmodule
`default_nettype wire

FILE: bench/integer_alu_with_divide_tb.sv
// Testbench top for integer_alu_with_divide: drives stimulus, random idling, verdict.
// Depends on ialu_pkg, ialu_checker and the block itself.
`default_nettype none
module integer_alu_with_divide_tb;
	import ialu_pkg::*;

	localparam int W = 64;
	localparam int LATENCY = W + 2;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_stall;
	logic [3:0]   operation = '0;
	logic [W-1:0] operand_a = '0;
	logic [W-1:0] operand_b = '0;
	logic         out_valid;
	logic         out_stall = 1'b0;
	logic [W-1:0] result;
	logic [1:0]   status;
	int           errors;
	int           pending;

	// idle rates in percent, changed per phase
	int unsigned  send_idle = 27;
	int unsigned  recv_idle = 86;
	int           sent = 0;

	integer_alu_with_divide #(.DATA_WIDTH(W)) dut (.*);

	ialu_checker #(.DATA_WIDTH(W)) chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver stall, changed only on falling edges
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle);

	// random operand with bias toward edge values
	function automatic logic [W-1:0] pick_operand();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return W'($urandom_range(70));
			3: return {1'b1, {(W-1){1'b0}}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// one item: optional idle gaps, then hold valid until accepted
	task automatic send_item(logic [3:0] op, logic [W-1:0] a, logic [W-1:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		logic [3:0] op;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every operation code, unused codes 11, 12 and 15, zero divisors, extreme operands and shifts
		send_item(K_ADD, '1, 1);
		send_item(K_SUB, 0, 1);
		send_item(K_MUL, '1, '1);
		send_item(K_DIV, '1, 0);
		send_item(K_REM, 5, 0);
		send_item(K_DIV, '1, 3);
		send_item(K_REM, '1, 10);
		send_item(K_DIV, 7, '1);
		send_item(K_XOR, '1, 64'h5555_aaaa_0f0f_f0f0);
		send_item(K_AND, '1, 64'h1234_5678_9abc_def0);
		send_item(K_OR,  0, '1);
		send_item(K_SHL, 1, 63);
		send_item(K_SHL, 1, 64);
		send_item(K_SHR, '1, 65);
		send_item(K_SHR, '1, '1);
		send_item(K_NOT, 0, '1);
		send_item(K_NOT, '1, 0);
		send_item(4'd11, '1, '1);
		send_item(4'd12, 1, 2);
		send_item(4'd15, '1, 0);
		drain();

		// random phases: three sender/receiver idle mixes, all results drained after each phase
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 27 : (phase == 1) ? 86 : 0;
			recv_idle = (phase == 0) ? 86 : (phase == 1) ? 27 : 0;
			repeat (150) begin
				op = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 11))
					: 4'($urandom_range(10));
				send_item(op, pick_operand(), pick_operand());
			end
			drain();
		end
		repeat (LATENCY + 10) @(negedge clk);

		$display("ran %0d items: all operation codes, zero divisors, shift wrap, edge operands,",
			sent);
		$display("under three sender/receiver idle mixes");
		if (errors == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
rtl/core/ialu_pkg.sv
rtl/core/ialu_front.sv
rtl/core/ialu_fifo.sv
rtl/core/ialu_back.sv
rtl/core/integer_alu_with_divide.sv
rtl/core/ialu_checker.sv
bench/ialu_checker.sv
bench/integer_alu_with_divide_tb.sv
